// File: hdl/rdq_pkg.sv
// rdq_pkg: shared types, codes and ring arithmetic for the reversible deque.
// No dependencies; used by rdq_ctrl and reversible_deque.
`default_nettype none

package rdq_pkg;

    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int OCC_W    = ADDR_W + 1;
    localparam int WORD_W   = 32;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    localparam logic [OCC_W-1:0]  DEPTH_OCC = OCC_W'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // action codes; anything else behaves as reverse
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    // single-port request to the word store
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } ram_req_t;

    // result loading instruction to the output register
    typedef struct packed {
        logic                load;
        logic                from_ram;
        logic [STATUS_W-1:0] status;
    } res_t;

    // (pos + delta) mod DEPTH, with pos < DEPTH and delta <= DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(
        input logic [ADDR_W-1:0] pos,
        input logic [OCC_W-1:0]  delta
    );
        logic [OCC_W-1:0] s;
        s = {1'b0, pos} + delta;
        if (s >= DEPTH_OCC)
        begin
            s = s - DEPTH_OCC;
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/rdq_ram.sv
// rdq_ram: generic single-port synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module rdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/rdq_ctrl.sv
// rdq_ctrl: pointer state, action decode and read interlock of the deque.
// Depends on rdq_pkg; drives the rdq_ram request and the output register load.
`default_nettype none

module rdq_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [rdq_pkg::ACTION_W-1:0]    action,
    input  wire logic signed [rdq_pkg::WORD_W-1:0] push_value,
    input  wire logic                            slot_free,
    output rdq_pkg::ram_req_t                    ram_req,
    output rdq_pkg::res_t                        res
);

    rdq_pkg::state_t                  state_reg, state_next;
    logic [rdq_pkg::ADDR_W-1:0]       head_reg, head_next;
    logic [rdq_pkg::OCC_W-1:0]        occ_reg, occ_next;
    logic                             rev_reg, rev_next;

    logic accept, is_push, is_pop, full, empty, phys_front;
    logic [rdq_pkg::ADDR_W-1:0] head_dec, head_inc, back_wr, back_rd;

    assign in_ready = (state_reg == rdq_pkg::ST_IDLE) && slot_free;
    assign accept   = in_valid && in_ready;

    assign is_push = (action == rdq_pkg::ACT_PUSH_FRONT) || (action == rdq_pkg::ACT_PUSH_BACK);
    assign is_pop  = (action == rdq_pkg::ACT_POP_FRONT) || (action == rdq_pkg::ACT_POP_BACK);
    assign full    = (occ_reg == rdq_pkg::DEPTH_OCC);
    assign empty   = (occ_reg == '0);

    // logical front maps to physical front unless reversed
    assign phys_front = ((action == rdq_pkg::ACT_PUSH_FRONT)
                         || (action == rdq_pkg::ACT_POP_FRONT)) != rev_reg;

    assign head_dec = (head_reg == '0) ? rdq_pkg::LAST_ADDR : head_reg - 1'b1;
    assign head_inc = rdq_pkg::ring_add(head_reg, rdq_pkg::OCC_W'(1));
    assign back_wr  = rdq_pkg::ring_add(head_reg, occ_reg);
    assign back_rd  = rdq_pkg::ring_add(head_reg, occ_reg - 1'b1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rdq_pkg::ST_IDLE:
            begin
                if (accept && is_pop && !empty)
                begin
                    state_next = rdq_pkg::ST_READ;
                end
            end
            rdq_pkg::ST_READ:
            begin
                state_next = rdq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rdq_pkg::ST_IDLE;
            end
        endcase
    end

    // pointer updates and outputs
    always_comb
    begin
        head_next     = head_reg;
        occ_next      = occ_reg;
        rev_next      = rev_reg;
        ram_req.en    = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.addr  = head_reg;
        ram_req.wdata = push_value;
        res.load      = 1'b0;
        res.from_ram  = 1'b0;
        res.status    = rdq_pkg::STAT_OK;
        unique case (state_reg)
            rdq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (is_push)
                    begin
                        if (full)
                        begin
                            res.load   = 1'b1;
                            res.status = rdq_pkg::STAT_FULL;
                        end
                        else
                        begin
                            ram_req.en   = 1'b1;
                            ram_req.we   = 1'b1;
                            ram_req.addr = phys_front ? head_dec : back_wr;
                            occ_next     = occ_reg + 1'b1;
                            if (phys_front)
                            begin
                                head_next = head_dec;
                            end
                        end
                    end
                    else if (is_pop)
                    begin
                        if (empty)
                        begin
                            res.load   = 1'b1;
                            res.status = rdq_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            ram_req.en   = 1'b1;
                            ram_req.addr = phys_front ? head_reg : back_rd;
                            occ_next     = occ_reg - 1'b1;
                            if (phys_front)
                            begin
                                head_next = head_inc;
                            end
                        end
                    end
                    else
                    begin
                        rev_next = !rev_reg;
                    end
                end
            end
            rdq_pkg::ST_READ:
            begin
                res.load     = 1'b1;
                res.from_ram = 1'b1;
                res.status   = rdq_pkg::STAT_OK;
            end
            default:
            begin
                res.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdq_pkg::ST_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
            rev_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
            rev_reg   <= rev_next;
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= rdq_pkg::DEPTH_OCC)
        else $error("occupancy beyond depth");

    a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rdq_pkg::ST_READ |-> !in_ready && res.load)
        else $error("read cycle did not block input or load result");

    a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_pop && !empty |=> state_reg == rdq_pkg::ST_READ
            && occ_reg == $past(occ_reg) - 1'b1)
        else $error("pop did not read and shrink");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_push && !full |=> occ_reg == $past(occ_reg) + 1'b1)
        else $error("push did not grow occupancy");

endmodule

`default_nettype wire

// File: hdl/reversible_deque.sv
// reversible_deque: bounded double-ended queue of signed 32-bit words.
// Usage notes:
//   Input channel (in_valid/in_ready) carries one word: action and push_value.
//   Actions: push front, push back, pop front, pop back, reverse (codes five
//   to seven also reverse). The reverse flag swaps the two ends.
//   Output channel (out_valid/out_ready) carries pop_value and status: one
//   word for every pop (value or empty status) and for every refused push.
//   Successful pushes and reverses produce no output word.
//   Timing: pushes, reverses and refused or empty actions finish at the
//   accepting edge, which also loads a refusal or empty status. A successful
//   pop adds the read state for the store's registered read, with in_ready
//   low; its word passes the store read register, then the output register.
//   An output register separates the channels: a new word is taken while the
//   previous result is still held, provided it leaves that cycle or the
//   register is empty. If the receiver stalls, the result stays put and
//   in_ready drops until it is taken.
//   Reset (rst_n low, asynchronous) empties the queue and clears the reverse
//   flag at once; no clearing pass runs, store contents are never read
//   before being written.
// Depends on rdq_pkg, rdq_ram and rdq_ctrl.
`default_nettype none

module reversible_deque (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [rdq_pkg::ACTION_W-1:0]      action,
    input  wire logic signed [rdq_pkg::WORD_W-1:0] push_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [rdq_pkg::WORD_W-1:0]      pop_value,
    output logic [rdq_pkg::STATUS_W-1:0]           status
);

    rdq_pkg::ram_req_t                ram_req;
    rdq_pkg::res_t                    res;
    logic [rdq_pkg::WORD_W-1:0]       ram_rdata;

    logic                             out_valid_reg, out_valid_next;
    logic [rdq_pkg::WORD_W-1:0]       value_reg, value_next;
    logic [rdq_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic                             slot_free;

    // output register is free at the next edge if empty or being taken now
    assign slot_free = !out_valid_reg || out_ready;

    rdq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .push_value (push_value),
        .slot_free  (slot_free),
        .ram_req    (ram_req),
        .res        (res)
    );

    // word store: at most one entry touched per action
    rdq_ram #(
        .WIDTH (rdq_pkg::WORD_W),
        .DEPTH (rdq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_req.en),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    // output register: loads a popped word or a status-only result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        priority if (res.load)
        begin
            out_valid_next = 1'b1;
            value_next     = res.from_ram ? ram_rdata : '0;
            status_next    = res.status;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign pop_value = value_reg;
    assign status    = status_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.load |-> slot_free)
        else $error("result loaded over a held word");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != rdq_pkg::STAT_OK |-> value_reg == '0)
        else $error("non-ok result carries a value");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(value_reg)
            && $stable(status_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire
